// ===== rtl/core/bpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types, constants and arithmetic helpers for the Bezier point
// evaluator: item layouts, cell control and the interpolation steps.
// ----------------------------------------------------------------------------
package bpdc_pkg;

   // Default capacity of the control point chain.
   localparam int MAX_POINTS_DEF = 16;

   // 1.0 in unsigned Q1.16.
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef logic signed [31:0] coord_type;
   typedef logic [16:0]        prog_type;
   typedef logic signed [49:0] prod_type;

   typedef struct packed {
      coord_type  point_x;
      coord_type  point_y;
      coord_type  point_z;
      prog_type   progress;
      logic       last_point;
   } req_type;

   typedef struct packed {
      coord_type  curve_x;
      coord_type  curve_y;
      coord_type  curve_z;
      logic       points_dropped;
   } rsp_type;

   typedef struct packed {
      coord_type  x;
      coord_type  y;
      coord_type  z;
   } point_type;

   // Per-cell strobes: load a new point, form the products, apply them.
   typedef struct packed {
      logic       wr;
      logic       mul;
      logic       add;
   } cell_ctrl_type;

   // (b - a) * p, exact in 50 bits for p <= 1.0.
   function automatic prod_type mul_step(coord_type a, coord_type b, prog_type p);
      logic signed [32:0] diff;
      logic signed [50:0] full;
      diff = {b[31], b} - {a[31], a};
      full = diff * $signed({1'b0, p});
      return full[49:0];
   endfunction

   // a + (prod >>> 16); the result always lies between the two points.
   function automatic coord_type add_step(coord_type a, prod_type prod);
      logic [33:0] sum;
      sum = {{2{a[31]}}, a} + prod[49:16];
      return sum[31:0];
   endfunction

endpackage

// ===== rtl/core/bezier_point_de_casteljau.sv =====
// ----------------------------------------------------------------------------
// bezier_point_de_casteljau
// Loads a run of 3D control points and, on the item marked last, evaluates
// the Bezier curve at the given progress by De Casteljau interpolation.
// ----------------------------------------------------------------------------
// Sequence: a non-last item is stored in the cycle it is accepted. A last item
// with N >= 2 stored points starts a pass: each interpolation level runs a
// product state and then a sum state in every active cell at once, and the
// done state then registers the result. With fewer than two points the
// sequencer goes straight to the done state and answers with the zero vector.
// A result still waiting in the output register does not stop loading, but
// the next curve then waits in the done state, with the input closed.
// Throughput: one item per cycle while loading; the input is closed from the
// last item of a run until its result enters the output register.
// Reset clears the point count, the overflow flag, the sequencer and the
// result valid; the stored points are not cleared.
// ----------------------------------------------------------------------------
module bezier_point_de_casteljau #(
   parameter int MAX_POINTS = bpdc_pkg::MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bpdc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bpdc_pkg::rsp_type  rsp_data
);
   import bpdc_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int LVL_W = $clog2(MAX_POINTS);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [LVL_W-1:0] level_ff, level_in;
   prog_type         prog_ff, prog_in;
   logic             drop_ff, drop_in;
   logic             zero_ff, zero_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             room;
   logic [CNT_W-1:0] count_new;
   point_type        new_point;
   point_type        cell_point [MAX_POINTS];
   cell_ctrl_type    cell_ctrl  [MAX_POINTS];

   // Items are taken only in the idle state. A finished curve waits in the done
   // state until the result register is free, with the input closed, so a
   // stalled receiver can also hold back the loading of the next run.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < CNT_W'(MAX_POINTS));
   assign count_new = room ? count_ff + CNT_W'(1) : count_ff;

   assign new_point = '{x: req_data.point_x, y: req_data.point_y, z: req_data.point_z};

   // The chain: cell i holds point i. All active cells of a level blend with
   // their old right neighbor at once, which matches the in-place pass.
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      point_type nbr;
      if (i == MAX_POINTS - 1) begin : g_end
         assign nbr = cell_point[i];
      end else begin : g_mid
         assign nbr = cell_point[i+1];
      end

      always_comb begin
         cell_ctrl[i].wr  = accept && room && (count_ff == CNT_W'(i));
         cell_ctrl[i].mul = (state_ff == ST_MUL) && (LVL_W'(i) < level_ff);
         cell_ctrl[i].add = (state_ff == ST_ADD) && (LVL_W'(i) < level_ff);
      end

      bpdc_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .wr_point  (new_point),
         .nbr_point (nbr),
         .progress  (prog_ff),
         .point     (cell_point[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      level_in     = level_ff;
      prog_in      = prog_ff;
      drop_in      = drop_ff;
      zero_in      = zero_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_data.last_point) begin
                  count_in = count_new;
                  ovf_in   = ovf_ff || !room;
               end else begin
                  // A run ends here: clear the run state and either start
                  // the pass or go straight on to answer with the zero vector.
                  count_in = '0;
                  ovf_in   = 1'b0;
                  drop_in  = ovf_ff || !room;
                  prog_in  = (req_data.progress > ONE_Q16) ? ONE_Q16 : req_data.progress;
                  level_in = LVL_W'(count_new - CNT_W'(1));
                  if (count_new >= CNT_W'(2)) begin
                     zero_in  = 1'b0;
                     state_in = ST_MUL;
                  end else begin
                     zero_in  = 1'b1;
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (level_ff == LVL_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               level_in = level_ff - LVL_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            // Cell 0 now holds the curve point and keeps it until the result
            // register can take it.
            if (!rsp_valid_ff || rsp_ready) begin
               if (zero_ff) begin
                  rsp_in = '{curve_x: '0, curve_y: '0, curve_z: '0,
                             points_dropped: drop_ff};
               end else begin
                  rsp_in = '{curve_x: cell_point[0].x, curve_y: cell_point[0].y,
                             curve_z: cell_point[0].z, points_dropped: drop_ff};
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      prog_ff  <= prog_in;
      drop_ff  <= drop_in;
      zero_ff  <= zero_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/bpdc_cell.sv =====
// ----------------------------------------------------------------------------
// bpdc_cell
// One link of the evaluation chain: holds one control point and blends it
// with its right-hand neighbor, the product first and the sum in the next cycle.
// ----------------------------------------------------------------------------
module bpdc_cell (
   input  logic                     clock,
   input  bpdc_pkg::cell_ctrl_type  ctrl,
   input  bpdc_pkg::point_type      wr_point,
   input  bpdc_pkg::point_type      nbr_point,
   input  bpdc_pkg::prog_type       progress,
   output bpdc_pkg::point_type      point
);
   import bpdc_pkg::*;

   point_type point_ff, point_in;
   prod_type  prod_x_ff, prod_y_ff, prod_z_ff;

   always_comb begin
      point_in = point_ff;
      if (ctrl.wr) begin
         point_in = wr_point;
      end else if (ctrl.add) begin
         point_in.x = add_step(point_ff.x, prod_x_ff);
         point_in.y = add_step(point_ff.y, prod_y_ff);
         point_in.z = add_step(point_ff.z, prod_z_ff);
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      if (ctrl.mul) begin
         prod_x_ff <= mul_step(point_ff.x, nbr_point.x, progress);
         prod_y_ff <= mul_step(point_ff.y, nbr_point.y, progress);
         prod_z_ff <= mul_step(point_ff.z, nbr_point.z, progress);
      end
   end

   assign point = point_ff;

endmodule

// ===== rtl/core/bpdc_checker.sv =====
// ----------------------------------------------------------------------------
// bpdc_checker
// Port-level checks for the Bezier point evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bpdc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input bpdc_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bpdc_pkg::rsp_type  rsp_data
);

   // A waiting result stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or vanished while stalled");

   // Reset leaves no result pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A last item either answers at once or blocks the input while it runs.
   a_last_reacts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_point |=> rsp_valid || !req_ready)
      else $error("last item accepted without result or evaluation");

   // A new result is only handed over out of a state with the input closed.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared unexpectedly");

endmodule

bind bezier_point_de_casteljau bpdc_checker u_bpdc_checker (.*);

// ===== verif/bpdc_curve_checker.sv =====
// ----------------------------------------------------------------------------
// bpdc_curve_checker
// Watches both channels of the Bezier point evaluator, keeps its own copy of
// the control point run, computes the curve point for every item marked
// last, and compares each result item field by field in arrival order.
// ----------------------------------------------------------------------------
module bpdc_curve_checker #(
   parameter int MAX_POINTS = bpdc_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  bpdc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  bpdc_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                curves_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import bpdc_pkg::*;

   coord_type ctl_x [MAX_POINTS];
   coord_type ctl_y [MAX_POINTS];
   coord_type ctl_z [MAX_POINTS];
   int        loaded;
   logic      spilled;
   rsp_type   curve_queue [$];

   // One linear step in Q16.16: a + floor((b - a) * p / 2^16).
   function automatic coord_type blend_q16(coord_type a, coord_type b, prog_type p);
      longint span;
      longint scale;
      span  = longint'(b) - longint'(a);
      scale = p;
      return coord_type'(longint'(a) + ((span * scale) >>> 16));
   endfunction

   // Collapses the stored run in place, level by level, and returns the point
   // left in entry 0 together with the drop flag of the run.
   function automatic rsp_type curve_at(prog_type p_raw);
      rsp_type  pt;
      prog_type p;
      int       lvl;
      int       i;
      p  = (p_raw > ONE_Q16) ? ONE_Q16 : p_raw;
      pt = '0;
      if (loaded >= 2) begin
         for (lvl = loaded - 1; lvl >= 1; lvl--) begin
            for (i = 0; i < lvl; i++) begin
               ctl_x[i] = blend_q16(ctl_x[i], ctl_x[i + 1], p);
               ctl_y[i] = blend_q16(ctl_y[i], ctl_y[i + 1], p);
               ctl_z[i] = blend_q16(ctl_z[i], ctl_z[i + 1], p);
            end
         end
         pt.curve_x = ctl_x[0];
         pt.curve_y = ctl_y[0];
         pt.curve_z = ctl_z[0];
      end
      pt.points_dropped = spilled;
      return pt;
   endfunction

   task automatic check_field(string label, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         loaded  = 0;
         spilled = 1'b0;
         curve_queue.delete();
      end else begin
         // Results are handled first: a result can never belong to an item
         // accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (curve_queue.size() == 0) begin
               $display("%0t: result item with no curve outstanding, actual x=%0d y=%0d z=%0d dropped=%0b",
                        $time, rsp_data.curve_x, rsp_data.curve_y, rsp_data.curve_z,
                        rsp_data.points_dropped);
               mismatch_count++;
            end else begin
               want = curve_queue.pop_front();
               check_field("curve_x", want.curve_x, rsp_data.curve_x);
               check_field("curve_y", want.curve_y, rsp_data.curve_y);
               check_field("curve_z", want.curve_z, rsp_data.curve_z);
               check_field("points_dropped", 32'(want.points_dropped),
                           32'(rsp_data.points_dropped));
            end
         end
         if (req_valid && req_ready) begin
            if (loaded < MAX_POINTS) begin
               ctl_x[loaded] = req_data.point_x;
               ctl_y[loaded] = req_data.point_y;
               ctl_z[loaded] = req_data.point_z;
               loaded++;
            end else begin
               spilled = 1'b1;
            end
            if (req_data.last_point) begin
               curve_queue.push_back(curve_at(req_data.progress));
               loaded  = 0;
               spilled = 1'b0;
            end
         end
      end
      curves_due <= curve_queue.size();
   end

endmodule

// ===== verif/bezier_point_de_casteljau_test.sv =====
// ----------------------------------------------------------------------------
// bezier_point_de_casteljau_test
// Drives runs of 3D control points into the Bezier point evaluator with
// random gaps on both channels and lets the checker compare every curve
// point it returns. A short directed part covers the field extremes and the
// corner cases, then random runs of mostly legal length follow.
// ----------------------------------------------------------------------------
module bezier_point_de_casteljau_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bpdc_pkg::*;

   localparam int ITEM_TARGET = 1650;
   // This limit covers even the slowest legal run, with a long sender gap, a
   // full sixteen-point evaluation and a long receiver stall on every item.
   localparam int CYCLE_LIMIT = 800000;
   // Wait at the end for longer than the deepest, sixteen-point evaluation.
   localparam int TAIL_CYCLES = 40;

   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int curves_due;
   int items_sent  = 0;
   int cycle_count = 0;
   int rx_tick     = 0;
   int ready_hold  = 0;

   always #1 clock = ~clock;

   bezier_point_de_casteljau dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bpdc_curve_checker curve_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatches),
      .curves_due     (curves_due)
   );

   // Idle lengths: mostly none, sometimes short, rarely a long pause.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Coordinates lean toward the extremes and toward small values, where the
   // floor of negative products and the end points are easiest to get wrong.
   function automatic coord_type draw_coord();
      case ($urandom_range(9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return -1;
         4, 5:    return coord_type'($urandom_range(0, 1 << 20)) - 32'sd524288;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Progress mostly within [0, 1.0]; some values above one, which the block
   // must clamp to exactly 1.0.
   function automatic prog_type draw_progress();
      case ($urandom_range(9))
         0:       return '0;
         1:       return ONE_Q16;
         2:       return 17'h1FFFF;
         3:       return prog_type'($urandom_range(65537, 131071));
         default: return prog_type'($urandom_range(0, 65536));
      endcase
   endfunction

   // Run lengths: mostly a legal chain of 2 to 16 points, a few lone points
   // and a few runs that overflow the point store.
   function automatic int draw_run_length();
      int r;
      r = $urandom_range(99);
      if (r < 5)  return 1;
      if (r < 85) return $urandom_range(2, 8);
      if (r < 95) return $urandom_range(9, MAX_POINTS_DEF);
      return $urandom_range(MAX_POINTS_DEF + 1, MAX_POINTS_DEF + 4);
   endfunction

   function automatic req_type make_point(coord_type x, coord_type y, coord_type z,
                                          prog_type p, logic is_last);
      req_type it;
      it.point_x    = x;
      it.point_y    = y;
      it.point_z    = z;
      it.progress   = p;
      it.last_point = is_last;
      return it;
   endfunction

   // Presents one item and holds it until the block takes it. Valid is only
   // lowered when a gap is wanted, so back-to-back items keep it high
   // without a drop inside the same time step.
   task automatic offer_point(input req_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the sender off until every curve point already owed has come
   // back. Valid is dropped first, and the wait begins once the checker has seen the last item.
   task automatic await_curves();
      req_valid <= 1'b0;
      @(posedge clock);
      while (curves_due != 0) @(posedge clock);
   endtask

   // Sends one run of random control points, the final one marked last. The
   // progress of the other items is ignored by the block but still toggles
   // every bit of that field.
   task automatic send_run(input int length, input bit calm);
      req_type item;
      int      k;
      for (k = 0; k < length; k++) begin
         item.point_x    = draw_coord();
         item.point_y    = draw_coord();
         item.point_z    = draw_coord();
         item.last_point = (k == length - 1);
         item.progress   = item.last_point ? draw_progress()
                                           : prog_type'($urandom_range(0, 131071));
         offer_point(item, calm ? 0 : draw_gap());
      end
   endtask

   // The receiver alternates random ready and stall stretches, with a
   // recurring window in which it never stalls at all.
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 3000 < 400) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         rsp_ready  <= 1'b0;
         ready_hold <= draw_gap();
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 6);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A lone point marked last must give the zero vector; its progress is
      // above one as well, which must not matter.
      offer_point(make_point(COORD_MAX, COORD_MIN, -1, 17'h1FFFF, 1'b1), 0);

      // Two points at opposite extremes, evaluated at exactly 1.0: the curve
      // lands on the last point, so the full 33-bit difference is exercised.
      offer_point(make_point(COORD_MIN, COORD_MAX, '0, '0, 1'b0), 0);
      offer_point(make_point(COORD_MAX, COORD_MIN, -1, ONE_Q16, 1'b1), 0);

      // Progress beyond one saturates, so again the last point comes back.
      offer_point(make_point('0, -1, COORD_MIN, '0, 1'b0), 0);
      offer_point(make_point(COORD_MIN, COORD_MAX, COORD_MAX, 17'h1FFFF, 1'b1), 0);

      // Progress zero returns the first point.
      offer_point(make_point(32'sd123456, -32'sd98765, COORD_MAX, 17'h0FFFF, 1'b0), 0);
      offer_point(make_point(COORD_MIN, '0, 32'sd1, '0, 1'b1), 0);

      // Halfway between the extremes, where the floor of a negative product
      // differs from truncation.
      offer_point(make_point(COORD_MIN, COORD_MAX, -3, '0, 1'b0), 0);
      offer_point(make_point(COORD_MAX, COORD_MIN, 3, 17'h08000, 1'b1), 0);

      // One point too many: the last item's point is dropped, but its
      // progress and trigger still apply and the drop flag must be raised.
      send_run(MAX_POINTS_DEF + 1, 1'b1);

      await_curves();

      // Random runs. Roughly one run in five goes without any sender gap.
      while (items_sent < ITEM_TARGET) begin
         send_run(draw_run_length(), $urandom_range(9) < 2);
         if (!paused && items_sent >= ITEM_TARGET / 2) begin
            await_curves();
            paused = 1'b1;
         end
      end

      await_curves();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
